@@ hdl/xesc_pkg.sv @@
// ----------------------------------------------------------------------------
// XML escape package
// Shared constants and types for the XML escaper with an output byte limit.
// ----------------------------------------------------------------------------
package xesc_pkg;

   // Width of the per-string output byte counter.
   localparam int COUNT_WIDTH = 16;
   localparam int LIMIT_WIDTH = 16;
   // The limit compare needs room for the counter plus one escape.
   localparam int CMP_W = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;
   localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   localparam int MAX_SEQ = 6;
   localparam int LEN_W   = 3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_LIMIT   = 1'd1;
   localparam logic [LIMIT_WIDTH-1:0] BYTE_LIMIT_RESET = 16'hFFFF;

   // Characters that need an entity, the NUL and dot bytes, and the printable range.
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_LT   = 8'h3C;
   localparam logic [7:0] CHAR_GT   = 8'h3E;
   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_QUOT = 8'h22;
   localparam logic [7:0] CHAR_APOS = 8'h27;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] PRINT_LO  = 8'd32;
   localparam logic [7:0] PRINT_HI  = 8'd126;

   // Entity text, first byte in element zero.
   localparam logic [MAX_SEQ-1:0][7:0] ESC_LT   = {8'h00, 8'h00, ";", "t", "l", "&"};
   localparam logic [MAX_SEQ-1:0][7:0] ESC_GT   = {8'h00, 8'h00, ";", "t", "g", "&"};
   localparam logic [MAX_SEQ-1:0][7:0] ESC_AMP  = {8'h00, ";", "p", "m", "a", "&"};
   localparam logic [MAX_SEQ-1:0][7:0] ESC_QUOT = {";", "t", "o", "u", "q", "&"};
   localparam logic [MAX_SEQ-1:0][7:0] ESC_APOS = {";", "s", "o", "p", "a", "&"};

   typedef struct packed {
      logic [MAX_SEQ-1:0][7:0] bytes;
      logic [LEN_W-1:0]        len;
   } esc_seq_type;

endpackage

@@ hdl/xesc_encode.sv @@
// ----------------------------------------------------------------------------
// XML escape encoder
// Maps one raw byte to its escaped byte sequence and that sequence's length.
// ----------------------------------------------------------------------------
module xesc_encode
   import xesc_pkg::*;
(
   input  logic [7:0]  char_in,
   output esc_seq_type seq
);

   always_comb begin
      seq.bytes = '0;
      seq.len   = LEN_W'(1);
      case (char_in)
         CHAR_LT: begin
            seq.bytes = ESC_LT;
            seq.len   = LEN_W'(4);
         end
         CHAR_GT: begin
            seq.bytes = ESC_GT;
            seq.len   = LEN_W'(4);
         end
         CHAR_AMP: begin
            seq.bytes = ESC_AMP;
            seq.len   = LEN_W'(5);
         end
         CHAR_QUOT: begin
            seq.bytes = ESC_QUOT;
            seq.len   = LEN_W'(6);
         end
         CHAR_APOS: begin
            seq.bytes = ESC_APOS;
            seq.len   = LEN_W'(6);
         end
         default: begin
            // Control and non-ASCII bytes print as a dot.
            if (char_in inside {[PRINT_LO:PRINT_HI]}) begin
               seq.bytes[0] = char_in;
            end else begin
               seq.bytes[0] = CHAR_DOT;
            end
         end
      endcase
   end

endmodule

@@ hdl/xml_escape_with_limit.sv @@
// The first output byte of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while each emits at most one byte and rsp_stall is
// low; a request that expands into an entity holds the output shift register until its
// last byte leaves. Requests that emit nothing (zero byte, truncated string) skip it.
// Reset (synchronous, active high) clears the count, the stop flag, rsp_valid, and
// sets the limit registers to disabled and 65535.
// ----------------------------------------------------------------------------
// XML escaper with output byte limit
// Escapes a byte stream into XML text, optionally capping the bytes per string.
// ----------------------------------------------------------------------------
module xml_escape_with_limit
   import xesc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_in,
   input  logic                   req_end_of_string,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_WIDTH-1:0] csr_data
);

   logic                    limit_en_ff,  limit_en_in;
   logic [LIMIT_WIDTH-1:0]  limit_ff,     limit_in;
   logic [COUNT_WIDTH-1:0]  count_ff,     count_in;
   logic                    trunc_ff,     trunc_in;
   logic                    valid_ff,     valid_in;
   logic                    last_ff,      last_in;
   logic [LEN_W-1:0]        rem_ff,       rem_in;
   logic [MAX_SEQ-1:0][7:0] sh_ff,        sh_in;

   esc_seq_type             seq;
   logic                    accept;
   logic                    pop;
   logic                    over;
   logic                    emit;
   logic [CMP_W-1:0]        sum;

   xesc_encode u_encode (
      .char_in (req_char_in),
      .seq     (seq)
   );

   assign csr_ready = 1'b1;

   // A new request may enter once the last byte of the previous one is leaving.
   assign req_stall = valid_ff && !(last_ff && !rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign pop       = valid_ff && !rsp_stall;

   assign sum  = CMP_W'(count_ff) + CMP_W'(seq.len);
   assign over = limit_en_ff && (sum > CMP_W'(limit_ff));
   assign emit = accept && (req_char_in != CHAR_NUL) && !trunc_ff && !over;

   always_comb begin
      limit_en_in = limit_en_ff;
      limit_in    = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LIMIT_ENABLE: limit_en_in = csr_data[0];
            REG_BYTE_LIMIT:   limit_in    = csr_data;
            default:          limit_in    = limit_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      trunc_in = trunc_ff;
      if (accept) begin
         if (req_char_in == CHAR_NUL || req_end_of_string) begin
            count_in = '0;
            trunc_in = 1'b0;
         end else if (!trunc_ff) begin
            if (over) begin
               trunc_in = 1'b1;
            end else if (sum > COUNT_MAX) begin
               count_in = COUNT_MAX[COUNT_WIDTH-1:0];
            end else begin
               count_in = sum[COUNT_WIDTH-1:0];
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      if (emit) begin
         valid_in = 1'b1;
         sh_in    = seq.bytes;
         rem_in   = seq.len;
         last_in  = (seq.len == LEN_W'(1));
      end else if (pop) begin
         valid_in = !last_ff;
         rem_in   = rem_ff - LEN_W'(1);
         last_in  = (rem_ff == LEN_W'(2));
         for (int i = 0; i < MAX_SEQ - 1; i++) begin
            sh_in[i] = sh_ff[i+1];
         end
         sh_in[MAX_SEQ-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_en_ff <= 1'b0;
         limit_ff    <= BYTE_LIMIT_RESET;
         count_ff    <= '0;
         trunc_ff    <= 1'b0;
         valid_ff    <= 1'b0;
         last_ff     <= 1'b0;
         rem_ff      <= '0;
      end else begin
         limit_en_ff <= limit_en_in;
         limit_ff    <= limit_in;
         count_ff    <= count_in;
         trunc_ff    <= trunc_in;
         valid_ff    <= valid_in;
         last_ff     <= last_in;
         rem_ff      <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = sh_ff[0];
   assign rsp_run_last = last_ff;

`ifndef ASSERT_OFF
   a_valid_has_bytes: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rem_ff != '0))
      else $error("output valid with no bytes left");

   a_last_matches_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == (rem_ff == LEN_W'(1))))
      else $error("last flag out of step with remaining count");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff)
      else $error("request stalled while output is empty");

   a_mid_seq_continues: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff && !rsp_stall) |=> valid_ff)
      else $error("escape sequence cut short");

   a_no_emit_truncated: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> !emit)
      else $error("bytes emitted in a truncated string");
`endif

endmodule
